/* src/sha1_pkg.sv */
package sha1_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_vars_t;

    typedef struct packed {
        logic       load_byte;
        logic       next_word;
        logic [7:0] byte_val;
    } sha1_sched_ctl_t;

    localparam sha1_vars_t SHA1_IV = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    // round function groups, 20 rounds each
    localparam logic [1:0] PH_CH   = 2'd0;
    localparam logic [1:0] PH_PAR1 = 2'd1;
    localparam logic [1:0] PH_MAJ  = 2'd2;
    localparam logic [1:0] PH_PAR2 = 2'd3;

    localparam logic [31:0] K_CH   = 32'h5a827999;
    localparam logic [31:0] K_PAR1 = 32'h6ed9eba1;
    localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
    localparam logic [31:0] K_PAR2 = 32'hca62c1d6;

    localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

/* src/sha1_sched.sv */
module sha1_sched (
    input  logic                      clk,
    input  sha1_pkg::sha1_sched_ctl_t ctl,
    output logic [31:0]               w
);
    import sha1_pkg::*;

    // word k of the window sits at bits [511-32k -: 32]; word 0 is the oldest
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  mix;
    logic [31:0]  new_word;

    assign mix      = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ win_reg[511:480];
    assign new_word = {mix[30:0], mix[31]};
    assign w        = win_reg[511:480];

    always_comb
    begin
        win_next = win_reg;
        if (ctl.load_byte)
        begin
            win_next = {win_reg[503:0], ctl.byte_val};
        end
        else if (ctl.next_word)
        begin
            // advance one word and append the next schedule word
            win_next = {win_reg[479:0], new_word};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

/* src/sha1_round.sv */
module sha1_round (
    input  sha1_pkg::sha1_vars_t cur,
    input  logic [31:0]          w,
    input  logic [1:0]           phase,
    output sha1_pkg::sha1_vars_t nxt
);
    import sha1_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb
    begin
        case (phase)
            PH_CH:
            begin
                f = (cur.b & cur.c) | (~cur.b & cur.d);
                k = K_CH;
            end
            PH_PAR1:
            begin
                f = cur.b ^ cur.c ^ cur.d;
                k = K_PAR1;
            end
            PH_MAJ:
            begin
                f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
                k = K_MAJ;
            end
            default:
            begin
                f = cur.b ^ cur.c ^ cur.d;
                k = K_PAR2;
            end
        endcase
    end

    assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;

    always_comb
    begin
        nxt.a = t;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

/* src/sha1_hash_engine_core.sv */
// SHA-1 engine taking one message byte per input beat. A beat with tuser set
// carries a byte; tlast ends the message, and the 160-bit digest comes out as
// one output beat. The 64th byte of a block starts the compression: 80 rounds
// through the one round unit, then a fold; tready stays low through both. A
// tlast beat then loads padding and the length one byte per cycle up to the
// block end and compresses again; one extra block is needed when fewer than
// nine bytes are free. The final fold also holds while an earlier digest is
// still unread. The digest waits in an output register, so the next message
// may start meanwhile.
module sha1_hash_engine_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // hash_word0 .. hash_word4, 32 bits each
);
    import sha1_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PAD   = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_FOLD  = 2'd3;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    logic [1:0]   state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  bits_reg, bits_next;
    sha1_vars_t   chain_reg, chain_next;
    sha1_vars_t   vars_reg, vars_next;
    logic         pend_pad_reg, pend_pad_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_ok_reg, len_ok_next;
    logic         final_reg, final_next;
    logic         out_valid_reg, out_valid_next;
    logic [159:0] out_data_reg, out_data_next;

    logic            accept;
    logic            out_free;
    logic            pad_len_eff;
    logic [7:0]      pad_byte;
    logic [7:0][7:0] len_bytes;
    logic [1:0]      phase;
    logic [31:0]     w;
    sha1_vars_t      round_out;
    sha1_vars_t      fold_sum;
    sha1_sched_ctl_t sched_ctl;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // length goes in only where the marker byte left room for all eight bytes
    assign pad_len_eff = pad_first_reg ? (pos_reg <= 6'd55) : len_ok_reg;
    assign len_bytes   = bits_reg;

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (pad_len_eff && (pos_reg >= 6'd56))
        begin
            pad_byte = len_bytes[3'd7 - pos_reg[2:0]];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        if (cnt_reg < 7'd20)
        begin
            phase = PH_CH;
        end
        else if (cnt_reg < 7'd40)
        begin
            phase = PH_PAR1;
        end
        else if (cnt_reg < 7'd60)
        begin
            phase = PH_MAJ;
        end
        else
        begin
            phase = PH_PAR2;
        end
    end

    always_comb
    begin
        sched_ctl.load_byte = (accept && s_tuser) || (state_reg == ST_PAD);
        sched_ctl.next_word = (state_reg == ST_ROUND);
        sched_ctl.byte_val  = (state_reg == ST_PAD) ? pad_byte : s_tdata;
    end

    sha1_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (w)
    );

    sha1_round u_round (
        .cur   (vars_reg),
        .w     (w),
        .phase (phase),
        .nxt   (round_out)
    );

    always_comb
    begin
        fold_sum.a = chain_reg.a + vars_reg.a;
        fold_sum.b = chain_reg.b + vars_reg.b;
        fold_sum.c = chain_reg.c + vars_reg.c;
        fold_sum.d = chain_reg.d + vars_reg.d;
        fold_sum.e = chain_reg.e + vars_reg.e;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        bits_next      = bits_reg;
        chain_next     = chain_reg;
        vars_next      = vars_reg;
        pend_pad_next  = pend_pad_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pad_first_next = 1'b1;
                    if (s_tuser)
                    begin
                        bits_next = bits_reg + 64'd8;
                        pos_next  = pos_reg + 6'd1;
                    end
                    if (s_tuser && (pos_reg == 6'd63))
                    begin
                        state_next    = ST_ROUND;
                        cnt_next      = '0;
                        vars_next     = chain_reg;
                        pend_pad_next = s_tlast;
                        final_next    = 1'b0;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pos_next       = pos_reg + 6'd1;
                pad_first_next = 1'b0;
                len_ok_next    = pad_len_eff;
                if (pos_reg == 6'd63)
                begin
                    state_next    = ST_ROUND;
                    cnt_next      = '0;
                    vars_next     = chain_reg;
                    final_next    = pad_len_eff;
                    pend_pad_next = !pad_len_eff;
                    // the extra block carries the length
                    len_ok_next   = 1'b1;
                end
            end
            ST_ROUND:
            begin
                vars_next = round_out;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            default:
            begin
                if (final_reg)
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {fold_sum.e, fold_sum.d, fold_sum.c,
                                          fold_sum.b, fold_sum.a};
                        chain_next     = SHA1_IV;
                        bits_next      = '0;
                        final_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    chain_next    = fold_sum;
                    pend_pad_next = 1'b0;
                    state_next    = pend_pad_reg ? ST_PAD : ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            bits_reg      <= '0;
            chain_reg     <= SHA1_IV;
            pend_pad_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            bits_reg      <= bits_next;
            chain_reg     <= chain_next;
            pend_pad_reg  <= pend_pad_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg     <= vars_next;
        out_data_reg <= out_data_next;
    end

    a_round_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (cnt_reg <= LAST_ROUND))
        else $error("round counter past last round");

    a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && cnt_reg == LAST_ROUND) |=> (state_reg == ST_FOLD))
        else $error("compression did not end in fold");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD && pos_reg == 6'd63) |=>
            (state_reg == ST_ROUND && cnt_reg == 7'd0 && pos_reg == 6'd0))
        else $error("full padded block did not start compression");

    a_digest_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD && final_reg && out_free) |=>
            (m_tvalid && chain_reg == SHA1_IV && bits_reg == 64'd0 && s_tready))
        else $error("digest delivery did not restart the chain");

endmodule

/* verif/sha1_hash_engine_core_test.sv */
module sha1_hash_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    typedef struct {
        logic [7:0] data_val;
        bit         has_byte;
        bit         is_last;
        bit         drain_first;
    } msg_beat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;     // [7:0] data_byte
    logic         s_tuser = 1'b0;      // [0] has_byte
    logic         s_tlast = 1'b0;      // last
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;             // hash_word0 .. hash_word4, 32 bits each

    sha1_hash_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // stimulus and expected digests
    msg_beat_t    beat_queue[$];
    logic [159:0] pending_digests[$];
    int           beats_total = 0;
    int           beats_taken = 0;
    int           msgs_total = 0;
    int           msg_bytes_total = 0;
    int           digests_checked = 0;
    int           error_count = 0;
    bit           beat_taken = 1'b0;

    // predictor state
    logic [31:0]  hash_chain[5];
    logic [7:0]   block_buf[64];
    int           buf_fill;
    logic [63:0]  msg_bit_len;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void load_chain_iv();
        hash_chain[0] = SHA1_IV.a;
        hash_chain[1] = SHA1_IV.b;
        hash_chain[2] = SHA1_IV.c;
        hash_chain[3] = SHA1_IV.d;
        hash_chain[4] = SHA1_IV.e;
        buf_fill = 0;
        msg_bit_len = '0;
    endfunction

    // 80 rounds over block_buf, folded into hash_chain
    function automatic void sha1_fold_block();
        logic [31:0] sched[16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int slot;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int r = 0; r < 80; r++) begin
            slot = r & 15;
            if (r >= 16) begin
                x = sched[(slot + 13) & 15] ^ sched[(slot + 8) & 15]
                    ^ sched[(slot + 2) & 15] ^ sched[slot];
                sched[slot] = rotl32(x, 1);
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            t = rotl32(a, 5) + f + e + sched[slot] + k;
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void absorb_beat(input logic [7:0] data_val, input bit has_byte,
                                        input bit is_last);
        if (has_byte) begin
            block_buf[buf_fill] = data_val;
            buf_fill++;
            msg_bit_len += 64'd8;
            if (buf_fill == 64) begin
                sha1_fold_block();
                buf_fill = 0;
            end
        end
        if (is_last) begin
            block_buf[buf_fill] = PAD_MARK;
            buf_fill++;
            // length no longer fits: close this block and pad a fresh one
            if (buf_fill > 56) begin
                for (int i = buf_fill; i < 64; i++)
                    block_buf[i] = 8'h00;
                sha1_fold_block();
                buf_fill = 0;
            end
            for (int i = buf_fill; i < 56; i++)
                block_buf[i] = 8'h00;
            for (int i = 0; i < 8; i++)
                block_buf[56 + i] = msg_bit_len[63 - 8*i -: 8];
            sha1_fold_block();
            pending_digests.push_back({hash_chain[4], hash_chain[3], hash_chain[2],
                                       hash_chain[1], hash_chain[0]});
            load_chain_iv();
        end
    endfunction

    function automatic void push_beat(input logic [7:0] data_val, input bit has_byte,
                                      input bit is_last, input bit drain_first);
        msg_beat_t bt;
        bt.data_val = data_val;
        bt.has_byte = has_byte;
        bt.is_last = is_last;
        bt.drain_first = drain_first;
        beat_queue.push_back(bt);
        beats_total++;
        if (has_byte)
            msg_bytes_total++;
        if (is_last)
            msgs_total++;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one message; returns the number of non-idle beats queued
    function automatic int queue_message(input int len, input bit end_on_byte,
                                         input int idle_pct, input bit drain_first);
        int n = 0;
        bit hold = drain_first;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < idle_pct) begin
                push_beat(8'($urandom), 1'b0, 1'b0, hold);
                hold = 1'b0;
            end
            push_beat(rand_byte(), 1'b1, end_on_byte && (i == len - 1), hold);
            hold = 1'b0;
            n++;
        end
        if (!end_on_byte || len == 0) begin
            push_beat(8'($urandom), 1'b0, 1'b1, hold);
            n++;
        end
        return n;
    endfunction

    // driver: bursts with random gaps, holds until the handshake completes
    int burst_left = 4;
    int gap_left = 0;

    always @(negedge clk) begin
        msg_beat_t bt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            s_tuser <= 1'b0;
            s_tlast <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (beat_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (beat_queue[0].drain_first && pending_digests.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                bt = beat_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= bt.data_val;
                s_tuser <= bt.has_byte;
                s_tlast <= bt.is_last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 200)
                                                           : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
                end
            end
        end
    end

    // receiver stall pattern: runs of always-ready, random, mostly-ready, stalled
    int rdy_mode = 0;
    int rdy_left = 0;

    always @(negedge clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(5, 60);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // monitor: check digest beats, then feed accepted input beats to the predictor
    always @(posedge clk) begin
        logic [159:0] want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_digests.size() == 0) begin
                    $display("%0t ns: digest beat with none expected, got %040h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_digests.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                            $display("%0t ns: hash_word%0d expected %08h got %08h",
                                     $time, i, want[32*i +: 32], m_tdata[32*i +: 32]);
                            error_count++;
                        end
                    end
                    digests_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_beat(s_tdata, s_tuser, s_tlast);
                beats_taken++;
            end
        end
        beat_taken <= rst_n && s_tvalid && s_tready;
    end

    initial begin
        int counted;
        int len;
        int tail;
        int boundary_lens[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

        load_chain_iv();
        for (int i = 0; i < 64; i++)
            block_buf[i] = 8'h00;

        // directed: idle beats, empty messages, "abc", single bytes at the extremes
        push_beat(8'hA5, 1'b0, 1'b0, 1'b0);
        push_beat(8'h5A, 1'b0, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0, 1'b0);
        push_beat(8'h61, 1'b1, 1'b0, 1'b0);
        push_beat(8'h62, 1'b1, 1'b0, 1'b0);
        push_beat(8'h63, 1'b1, 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        push_beat(8'h80, 1'b1, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h7F, 1'b1, 1'b0, 1'b0);
        push_beat(8'h01, 1'b0, 1'b1, 1'b0);

        // random messages, short ones mostly, padding boundaries often
        counted = 0;
        while (counted < 1300) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 12);
                4, 5:       len = boundary_lens[$urandom_range(0, 9)];
                6:          len = 0;
                default:    len = $urandom_range(0, 140);
            endcase
            counted += queue_message(len, 1'($urandom_range(0, 1)),
                                     $urandom_range(0, 1) ? 0 : $urandom_range(1, 20),
                                     $urandom_range(0, 7) == 0);
        end
        // trailing bytes with no end leave the engine mid-message
        void'(queue_message(0, 1'b0, 0, 1'b1));
        tail = $urandom_range(1, 70);
        for (int i = 0; i < tail; i++)
            push_beat(rand_byte(), 1'b1, 1'b0, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_taken != beats_total || pending_digests.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Fed %0d beats: %0d messages, %0d message bytes; %0d digests checked.",
                 beats_total, msgs_total, msg_bytes_total, digests_checked);
        if (error_count == 0 && pending_digests.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #25ms;
        $display("Timed out with %0d of %0d beats taken, %0d digests outstanding",
                 beats_taken, beats_total, pending_digests.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
